>>> rtl/pfc_pkg.sv
package pfc_pkg;

	localparam int ByteW = 8;
	localparam int FmtW  = 3;

	localparam logic [FmtW-1:0] SRC_RGBA = 3'd0;
	localparam logic [FmtW-1:0] SRC_BGRA = 3'd1;
	localparam logic [FmtW-1:0] SRC_RGB  = 3'd2;
	localparam logic [FmtW-1:0] SRC_BGR  = 3'd3;
	localparam logic [FmtW-1:0] SRC_GRAY = 3'd4;
	localparam logic [FmtW-1:0] SRC_NV21 = 3'd5;
	localparam logic [FmtW-1:0] SRC_NV12 = 3'd6;

	localparam logic [FmtW-1:0] DST_RGBA = 3'd0;
	localparam logic [FmtW-1:0] DST_BGRA = 3'd1;
	localparam logic [FmtW-1:0] DST_RGB  = 3'd2;
	localparam logic [FmtW-1:0] DST_BGR  = 3'd3;
	localparam logic [FmtW-1:0] DST_GRAY = 3'd4;

	localparam logic [0:0] CFG_SRC_FORMAT = 1'b0;
	localparam logic [0:0] CFG_DST_FORMAT = 1'b1;

	localparam logic [2:0] NVALID_NONE = 3'd0;
	localparam logic [2:0] NVALID_GRAY = 3'd1;
	localparam logic [2:0] NVALID_RGB  = 3'd3;
	localparam logic [2:0] NVALID_RGBA = 3'd4;

	localparam logic [ByteW-1:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic            valid;
		logic            last;
		logic [FmtW-1:0] src;
		logic [FmtW-1:0] dst;
	} pfc_ctrl_t;

	typedef struct packed {
		pfc_ctrl_t        ctrl;
		logic [ByteW-1:0] r;
		logic [ByteW-1:0] g;
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] a;
		logic [ByteW-1:0] y;
		logic [ByteW-1:0] luma;
	} pfc_pix_t;

endpackage

>>> rtl/pfc_core.sv
module pfc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::pfc_ctrl_t ctrl_in,
	input  logic [7:0]        byte0,
	input  logic [7:0]        byte1,
	input  logic [7:0]        byte2,
	input  logic [7:0]        byte3,
	output pfc_pkg::pfc_pix_t  pix
);
	import pfc_pkg::*;

	// stage 1: input capture
	pfc_ctrl_t        ctrl_s1;
	logic [ByteW-1:0] b0_s1, b1_s1, b2_s1, b3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		b0_s1 <= byte0;
		b1_s1 <= byte1;
		b2_s1 <= byte2;
		b3_s1 <= byte3;
	end

	// stage 1 -> 2: channel select and products
	logic [ByteW-1:0]   r_c, g_c, b_c, a_c;
	logic signed [17:0] c1, c2, u_c, v_c;
	logic signed [17:0] m73v_c, m25u_c, m37v_c, m130u_c;
	logic [13:0]        lr_c, lg_c, lb_c;

	always_comb begin
		r_c = b0_s1;
		g_c = b1_s1;
		b_c = b2_s1;
		a_c = ALPHA_OPAQUE;
		case (ctrl_s1.src)
			SRC_RGBA: begin
				a_c = b3_s1;
			end
			SRC_BGRA: begin
				r_c = b2_s1;
				b_c = b0_s1;
				a_c = b3_s1;
			end
			SRC_BGR: begin
				r_c = b2_s1;
				b_c = b0_s1;
			end
			SRC_GRAY: begin
				g_c = b0_s1;
				b_c = b0_s1;
			end
			default: ;
		endcase
	end

	assign c1 = $signed({10'd0, b1_s1}) - 18'sd128;
	assign c2 = $signed({10'd0, b2_s1}) - 18'sd128;
	assign v_c = (ctrl_s1.src == SRC_NV21) ? c1 : c2;
	assign u_c = (ctrl_s1.src == SRC_NV21) ? c2 : c1;

	assign m73v_c  = v_c * 18'sd73;
	assign m25u_c  = u_c * 18'sd25;
	assign m37v_c  = v_c * 18'sd37;
	assign m130u_c = u_c * 18'sd130;
	assign lr_c    = 14'(r_c) * 14'd19;
	assign lg_c    = 14'(g_c) * 14'd38;
	assign lb_c    = 14'(b_c) * 14'd7;

	pfc_ctrl_t          ctrl_s2;
	logic [ByteW-1:0]   r_s2, g_s2, b_s2, a_s2, y_s2;
	logic signed [17:0] m73v_s2, m25u_s2, m37v_s2, m130u_s2;
	logic [13:0]        lr_s2, lg_s2, lb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s2     <= r_c;
		g_s2     <= g_c;
		b_s2     <= b_c;
		a_s2     <= a_c;
		y_s2     <= b0_s1;
		m73v_s2  <= m73v_c;
		m25u_s2  <= m25u_c;
		m37v_s2  <= m37v_c;
		m130u_s2 <= m130u_c;
		lr_s2    <= lr_c;
		lg_s2    <= lg_c;
		lb_s2    <= lb_c;
	end

	// stage 2 -> 3: sums
	logic signed [17:0] y64_c;
	assign y64_c = $signed({4'd0, y_s2, 6'd0});

	pfc_ctrl_t          ctrl_s3;
	logic [ByteW-1:0]   r_s3, g_s3, b_s3, a_s3, y_s3;
	logic signed [17:0] sr_s3, sg_s3, sb_s3;
	logic [13:0]        lsum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3    <= r_s2;
		g_s3    <= g_s2;
		b_s3    <= b_s2;
		a_s3    <= a_s2;
		y_s3    <= y_s2;
		sr_s3   <= y64_c + m73v_s2;
		sg_s3   <= y64_c - m25u_s2 - m37v_s2;
		sb_s3   <= y64_c + m130u_s2;
		lsum_s3 <= lr_s2 + lg_s2 + lb_s2;
	end

	// stage 3 out: clamp
	function automatic logic [ByteW-1:0] clamp_sum(input logic signed [17:0] s);
		logic [ByteW-1:0] res;
		if (s[17])
			res = '0;
		else if (|s[16:14])
			res = 8'd255;
		else
			res = s[13:6];
		return res;
	endfunction

	logic is_yuv_s3;
	assign is_yuv_s3 = (ctrl_s3.src == SRC_NV21) || (ctrl_s3.src == SRC_NV12);

	always_comb begin
		pix.ctrl = ctrl_s3;
		pix.r    = is_yuv_s3 ? clamp_sum(sr_s3) : r_s3;
		pix.g    = is_yuv_s3 ? clamp_sum(sg_s3) : g_s3;
		pix.b    = is_yuv_s3 ? clamp_sum(sb_s3) : b_s3;
		pix.a    = a_s3;
		pix.y    = y_s3;
		pix.luma = lsum_s3[13:6];
	end

	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s1.valid |=> ctrl_s2.valid)
		else $error("stage 2 lost a transaction");
	a_ctrl_flow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s2.valid |=> ctrl_s3.valid && ctrl_s3.src == $past(ctrl_s2.src))
		else $error("stage 3 control mismatch");
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl_s2.valid |=> !ctrl_s3.valid)
		else $error("stage 3 invented a transaction");

endmodule

>>> rtl/pixel_format_converter_unit.sv
// Channel   Signals                                        Handshake
// config    cfg_we, cfg_addr, cfg_wdata                    write on cfg_we
// pixel in  in_byte0..3, last_pixel                        start && !busy
// pixel out out_byte0..3, valid_bytes, format_error,       done, one cycle
//           last_out
//
// One pixel per clock; busy stays low, so start may be held every cycle.
// An accepted transaction passes through input capture, products, sums and the
// clamp/format result register, and done then rises together with its result.
// Reset clears the format registers to RGBA -> RGBA and empties the pipeline.
// The receiver cannot stall; results are never held back.
module pixel_format_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_addr,
	input  logic [2:0] cfg_wdata,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] in_byte0,
	input  logic [7:0] in_byte1,
	input  logic [7:0] in_byte2,
	input  logic [7:0] in_byte3,
	input  logic       last_pixel,
	output logic       done,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [2:0] valid_bytes,
	output logic       format_error,
	output logic       last_out
);
	import pfc_pkg::*;

	logic [FmtW-1:0] src_q, dst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_RGBA;
			dst_q <= DST_RGBA;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SRC_FORMAT: src_q <= cfg_wdata;
				CFG_DST_FORMAT: dst_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	pfc_ctrl_t ctrl_in;
	pfc_pix_t  pix;

	always_comb begin
		ctrl_in.valid = start && !busy;
		ctrl_in.last  = last_pixel;
		ctrl_in.src   = src_q;
		ctrl_in.dst   = dst_q;
	end

	pfc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_in),
		.byte0   (in_byte0),
		.byte1   (in_byte1),
		.byte2   (in_byte2),
		.byte3   (in_byte3),
		.pix     (pix)
	);

	// format select
	logic             yuv_c, four_ok_c, ok_c;
	logic [ByteW-1:0] o0_c, o1_c, o2_c, o3_c;
	logic [2:0]       nv_c;

	assign yuv_c     = (pix.ctrl.src == SRC_NV21) || (pix.ctrl.src == SRC_NV12);
	assign four_ok_c = (pix.ctrl.src == SRC_RGBA) || (pix.ctrl.src == SRC_BGRA) ||
	                   (pix.ctrl.src == SRC_GRAY);

	always_comb begin
		ok_c = (pix.ctrl.src <= SRC_NV12);
		o0_c = '0;
		o1_c = '0;
		o2_c = '0;
		o3_c = '0;
		nv_c = NVALID_NONE;
		case (pix.ctrl.dst)
			DST_RGBA: begin
				ok_c = ok_c && (four_ok_c || yuv_c);
				o0_c = pix.r;
				o1_c = pix.g;
				o2_c = pix.b;
				o3_c = pix.a;
				nv_c = NVALID_RGBA;
			end
			DST_BGRA: begin
				ok_c = ok_c && four_ok_c;
				o0_c = pix.b;
				o1_c = pix.g;
				o2_c = pix.r;
				o3_c = pix.a;
				nv_c = NVALID_RGBA;
			end
			DST_RGB: begin
				o0_c = pix.r;
				o1_c = pix.g;
				o2_c = pix.b;
				nv_c = NVALID_RGB;
			end
			DST_BGR: begin
				o0_c = pix.b;
				o1_c = pix.g;
				o2_c = pix.r;
				nv_c = NVALID_RGB;
			end
			DST_GRAY: begin
				o0_c = (pix.ctrl.src >= SRC_GRAY) ? pix.y : pix.luma;
				nv_c = NVALID_GRAY;
			end
			default: ok_c = 1'b0;
		endcase
		if (!ok_c) begin
			o0_c = '0;
			o1_c = '0;
			o2_c = '0;
			o3_c = '0;
			nv_c = NVALID_NONE;
		end
	end

	// stage 4: result register
	logic             valid_s4;
	logic [ByteW-1:0] o0_s4, o1_s4, o2_s4, o3_s4;
	logic [2:0]       nv_s4;
	logic             err_s4, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= pix.ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		o0_s4   <= o0_c;
		o1_s4   <= o1_c;
		o2_s4   <= o2_c;
		o3_s4   <= o3_c;
		nv_s4   <= nv_c;
		err_s4  <= !ok_c;
		last_s4 <= pix.ctrl.last;
	end

	assign done         = valid_s4;
	assign out_byte0    = o0_s4;
	assign out_byte1    = o1_s4;
	assign out_byte2    = o2_s4;
	assign out_byte3    = o3_s4;
	assign valid_bytes  = nv_s4;
	assign format_error = err_s4;
	assign last_out     = last_s4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted transaction did not complete in four cycles");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && format_error |-> valid_bytes == NVALID_NONE && out_byte0 == 8'd0 &&
		out_byte1 == 8'd0 && out_byte2 == 8'd0 && out_byte3 == 8'd0)
		else $error("error result carries data");
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && !format_error |-> valid_bytes == NVALID_GRAY ||
		valid_bytes == NVALID_RGB || valid_bytes == NVALID_RGBA)
		else $error("valid_bytes wrong for good result");
	a_gray_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_bytes == NVALID_GRAY |-> out_byte1 == 8'd0 && out_byte2 == 8'd0 &&
		out_byte3 == 8'd0)
		else $error("gray result has stray bytes");

endmodule
